// ===== sv/brr_pkg.sv =====
// ----------------------------------------------------------------------------
// brr_pkg: shared types and constants for the BRR ADPCM block decoder
// Header fields, predictor filter codes and arithmetic limits.
// ----------------------------------------------------------------------------
package brr_pkg;

   // working width of the predictor sum (covers the worst case of filter 3)
   localparam int AccW = 20;

   // largest scale that shifts the nibble; above it only the sign is kept
   localparam logic [3:0] ScaleMax = 4'd12;

   localparam logic signed [AccW-1:0] SignOnly = AccW'(-2048);
   localparam logic signed [AccW-1:0] AccMin   = AccW'(-32768);
   localparam logic signed [AccW-1:0] AccMax   = AccW'(32767);

   // predictor filter selected by header bits 3:2
   typedef enum logic [1:0] {
      FILT_NONE  = 2'd0,
      FILT_ONE   = 2'd1,
      FILT_TWO   = 2'd2,
      FILT_THREE = 2'd3
   } filter_type;

   // block header as held for the data bytes that follow it
   typedef struct packed {
      logic [3:0] scale;
      filter_type filter;
      logic       loop_bit;
      logic       end_bit;
   } hdr_type;

endpackage

// ===== sv/brr_nibble_dec.sv =====
// ----------------------------------------------------------------------------
// brr_nibble_dec: one-nibble ADPCM decode
// Scales a signed nibble, adds the selected prediction over two history
// samples, clamps to 16 bits and doubles with 16-bit wrap.
// ----------------------------------------------------------------------------
module brr_nibble_dec import brr_pkg::*; (
   input  logic [3:0]         nibble,
   input  hdr_type            hdr,
   input  logic signed [15:0] hist_new,
   input  logic signed [15:0] hist_old,
   output logic signed [15:0] sample
);

   logic signed [AccW-1:0] nib_x;
   logic signed [AccW-1:0] shifted;
   logic signed [AccW-1:0] scaled;
   logic signed [AccW-1:0] p1;
   logic signed [AccW-1:0] p2;
   logic signed [AccW-1:0] p1_x3;
   logic signed [AccW-1:0] p1_x13;
   logic signed [AccW-1:0] p2_x3;
   logic signed [AccW-1:0] pred;
   logic signed [AccW-1:0] sum;
   logic signed [15:0]     clamped;

   // scale the nibble, or keep only its sign for large scales
   always_comb begin
      nib_x   = {{(AccW-4){nibble[3]}}, nibble};
      shifted = nib_x <<< hdr.scale;
      if (hdr.scale <= ScaleMax) begin
         scaled = shifted >>> 1;
      end else begin
         scaled = nibble[3] ? SignOnly : '0;
      end
   end

   // halved history and small constant multiples
   always_comb begin
      p1     = $signed({{(AccW-16){hist_new[15]}}, hist_new}) >>> 1;
      p2     = $signed({{(AccW-16){hist_old[15]}}, hist_old}) >>> 1;
      p1_x3  = p1 + (p1 <<< 1);
      p1_x13 = (p1 <<< 3) + (p1 <<< 2) + p1;
      p2_x3  = p2 + (p2 <<< 1);
   end

   // predictor filters
   always_comb begin
      case (hdr.filter)
         FILT_NONE:  pred = '0;
         FILT_ONE:   pred = p1 + ((-p1) >>> 4);
         FILT_TWO:   pred = (p1 <<< 1) + ((-p1_x3) >>> 5) - p2 + (p2 >>> 4);
         FILT_THREE: pred = (p1 <<< 1) + ((-p1_x13) >>> 6) - p2 + (p2_x3 >>> 4);
         default:    pred = '0;
      endcase
   end

   // clamp to 16 bits, then double with wrap
   always_comb begin
      sum = scaled + pred;
      if (sum < AccMin) begin
         clamped = AccMin[15:0];
      end else if (sum > AccMax) begin
         clamped = AccMax[15:0];
      end else begin
         clamped = sum[15:0];
      end
      sample = {clamped[14:0], 1'b0};
   end

endmodule

// ===== sv/brr_adpcm_block_decoder.sv =====
// ----------------------------------------------------------------------------
// brr_adpcm_block_decoder: BRR ADPCM block decoder, one byte per item
// Usage:
//   req_* carries the bytes of 9-byte blocks. An item with req_tuser[0] set
//   is a header: it loads scale, filter, loop and end and gives no result
//   (req_tuser[1] with it makes the header read as zero). Every other item
//   is a data byte and gives two samples on rsp_*, high nibble first;
//   rsp_tlast marks the second one.
//   Each sample is decoded from the byte in the input register and is then
//   held in the result register.
//   A data byte is decoded one nibble at a time, because the shared nibble
//   decoder feeds each sample back into the filter history; the next item
//   is taken as the low nibble is decoded, and a header needs no free output.
//   The input register takes a new item while the result register still
//   holds a sample that the receiver has not taken.
//   Stall: while rsp_tready is low and a result is held, decoding stops
//   and req_tready falls once the input register holds a data byte.
//   Reset clears history, header state and the byte position to zero and
//   empties both registers.
// ----------------------------------------------------------------------------
module brr_adpcm_block_decoder import brr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] block_start, [1] ignore_header
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] pcm_sample, [19:16] sample_index, [23:20] zero
   output logic [1:0]  rsp_tuser,   // [0] loop_flag, [1] end_flag
   output logic        rsp_tlast    // last
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_start_ff;
   logic               in_ignore_ff;
   logic               phase_ff, phase_in;
   hdr_type            hdr_ff, hdr_in;
   logic [2:0]         pos_ff, pos_in;
   logic signed [15:0] hist_new_ff, hist_new_in;
   logic signed [15:0] hist_old_ff, hist_old_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff;
   logic [3:0]         rsp_index_ff;
   logic               rsp_loop_ff;
   logic               rsp_end_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               is_hdr;
   logic               do_sample;
   logic               consume;
   logic [3:0]         nibble;
   logic [7:0]         hdr_bits;
   logic signed [15:0] dec_sample;

   // handshake and work selection
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      is_hdr     = in_valid_ff && in_start_ff;
      do_sample  = in_valid_ff && !in_start_ff && out_free;
      consume    = is_hdr || (do_sample && phase_ff);
      req_tready = !in_valid_ff || consume;
      nibble     = phase_ff ? in_byte_ff[3:0] : in_byte_ff[7:4];
      hdr_bits   = in_ignore_ff ? 8'd0 : in_byte_ff;
   end

   brr_nibble_dec u_dec (
      .nibble   (nibble),
      .hdr      (hdr_ff),
      .hist_new (hist_new_ff),
      .hist_old (hist_old_ff),
      .sample   (dec_sample)
   );

   // next state of control, header and history
   always_comb begin
      in_valid_in  = in_valid_ff;
      phase_in     = phase_ff;
      hdr_in       = hdr_ff;
      pos_in       = pos_ff;
      hist_new_in  = hist_new_ff;
      hist_old_in  = hist_old_ff;
      rsp_valid_in = rsp_valid_ff;

      if (req_tready) begin
         in_valid_in = req_tvalid;
      end

      if (is_hdr) begin
         hdr_in.scale    = hdr_bits[7:4];
         hdr_in.filter   = filter_type'(hdr_bits[3:2]);
         hdr_in.loop_bit = hdr_bits[1];
         hdr_in.end_bit  = hdr_bits[0];
         pos_in          = '0;
      end

      if (do_sample) begin
         hist_old_in = hist_new_ff;
         hist_new_in = dec_sample;
         phase_in    = !phase_ff;
         if (phase_ff) begin
            pos_in = pos_ff + 3'd1;
         end
      end

      if (do_sample) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         hdr_ff       <= '0;
         pos_ff       <= '0;
         hist_new_ff  <= '0;
         hist_old_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         hdr_ff       <= hdr_in;
         pos_ff       <= pos_in;
         hist_new_ff  <= hist_new_in;
         hist_old_ff  <= hist_old_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input payload: load on accept
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff   <= req_tdata;
         in_start_ff  <= req_tuser[0];
         in_ignore_ff <= req_tuser[1];
      end
   end

   // result payload: load with each decoded sample
   always_ff @(posedge clock) begin
      if (do_sample) begin
         rsp_sample_ff <= dec_sample;
         rsp_index_ff  <= {pos_ff, phase_ff};
         rsp_loop_ff   <= hdr_ff.loop_bit;
         rsp_end_ff    <= hdr_ff.end_bit;
         rsp_last_ff   <= phase_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_index_ff, rsp_sample_ff};
   assign rsp_tuser  = {rsp_end_ff, rsp_loop_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a pending low nibble always belongs to a held data byte
   a_phase_has_byte: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (in_valid_ff && !in_start_ff))
      else $error("low nibble pending without a held data byte");

   // the second sample of a byte has an odd index, the first an even one
   a_last_matches_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16] == rsp_tlast))
      else $error("sample index and last disagree");

   // a first sample is followed by the second one of the same byte
   a_low_follows_high: assert property (@(posedge clock) disable iff (reset)
      (do_sample && !phase_ff) |=> (phase_ff && in_valid_ff))
      else $error("high nibble not followed by low nibble");

   // a held data byte with a blocked output keeps the input closed
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_start_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input opened while decoding is stalled");
`endif

endmodule
